// File: design/spwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwc_pkg
// Shared types, codes and constants for the servo pulse-width controller.
// ----------------------------------------------------------------------------
package spwc_pkg;

  localparam int unsigned WidthW = 11;
  localparam int unsigned CmpW   = 13;
  localparam int unsigned KeyW   = 3;

  typedef enum logic [1:0] {
    MODE_CENTER = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_AUTO   = 2'd2
  } mode_e;

  typedef enum logic [KeyW-1:0] {
    KEY_OK    = 3'd0,
    KEY_LEFT  = 3'd1,
    KEY_RIGHT = 3'd2,
    KEY_DOWN  = 3'd3,
    KEY_UP    = 3'd4
  } key_e;

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [WidthW-1:0] WIDTH_CENTER = 11'd1500;
  localparam logic [WidthW-1:0] WIDTH_MIN    = 11'd1000;
  localparam logic [WidthW-1:0] WIDTH_MAX    = 11'd2000;
  localparam logic [WidthW-1:0] SWEEP_LOW    = 11'd1010;
  localparam logic [WidthW-1:0] SWEEP_HIGH   = 11'd1990;
  localparam logic [WidthW-1:0] STEP_FINE    = 11'd1;
  localparam logic [WidthW-1:0] STEP_COARSE  = 11'd10;

  // x/5 == (x * 52429) >> 18 for every x below 81920
  localparam logic [15:0] RECIP5      = 16'd52429;
  localparam int unsigned RECIP5_SHIFT = 18;

  typedef struct packed {
    mode_e             mode;
    logic [WidthW-1:0] width;
    logic              dir_up;
  } ctl_state_t;

  typedef struct packed {
    logic            req_type;
    logic [KeyW-1:0] key_code;
    logic            is_release;
  } req_t;

endpackage

// File: design/spwc_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwc_update
// Next mode, width and sweep direction for one key or tick item.
// ----------------------------------------------------------------------------
module spwc_update (
  input  spwc_pkg::ctl_state_t cur_i,
  input  spwc_pkg::req_t       req_i,
  output spwc_pkg::ctl_state_t nxt_o,
  output logic                 wrote_o
);

  logic [spwc_pkg::WidthW-1:0] tick_w;

  assign tick_w = cur_i.dir_up ? (cur_i.width + spwc_pkg::STEP_FINE)
                               : (cur_i.width - spwc_pkg::STEP_FINE);

  always_comb begin
    nxt_o   = cur_i;
    wrote_o = 1'b0;
    if (req_i.req_type == spwc_pkg::REQ_KEY) begin
      case (req_i.key_code)
        spwc_pkg::KEY_OK: begin
          if (req_i.is_release) begin
            case (cur_i.mode)
              spwc_pkg::MODE_CENTER: nxt_o.mode = spwc_pkg::MODE_MANUAL;
              spwc_pkg::MODE_MANUAL: nxt_o.mode = spwc_pkg::MODE_AUTO;
              default:               nxt_o.mode = spwc_pkg::MODE_CENTER;
            endcase
            if (nxt_o.mode == spwc_pkg::MODE_CENTER) begin
              nxt_o.width = spwc_pkg::WIDTH_CENTER;
              wrote_o     = 1'b1;
            end
          end
        end
        spwc_pkg::KEY_LEFT: begin
          if (cur_i.width > spwc_pkg::WIDTH_MIN)
            nxt_o.width = cur_i.width - spwc_pkg::STEP_FINE;
          wrote_o = 1'b1;
        end
        spwc_pkg::KEY_RIGHT: begin
          if (cur_i.width < spwc_pkg::WIDTH_MAX)
            nxt_o.width = cur_i.width + spwc_pkg::STEP_FINE;
          wrote_o = 1'b1;
        end
        spwc_pkg::KEY_DOWN: begin
          if (cur_i.width >= spwc_pkg::SWEEP_LOW)
            nxt_o.width = cur_i.width - spwc_pkg::STEP_COARSE;
          wrote_o = 1'b1;
        end
        spwc_pkg::KEY_UP: begin
          if (cur_i.width <= spwc_pkg::SWEEP_HIGH)
            nxt_o.width = cur_i.width + spwc_pkg::STEP_COARSE;
          wrote_o = 1'b1;
        end
        default: ;
      endcase
    end else if (cur_i.mode == spwc_pkg::MODE_AUTO) begin
      nxt_o.width = tick_w;
      if ((tick_w > spwc_pkg::SWEEP_HIGH) || (tick_w < spwc_pkg::SWEEP_LOW))
        nxt_o.dir_up = ~cur_i.dir_up;
      wrote_o = 1'b1;
    end
  end

endmodule

// File: design/spwc_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwc_compare
// Timer compare floor(width*16/5) by reciprocal multiply.
// ----------------------------------------------------------------------------
module spwc_compare (
  input  logic [spwc_pkg::WidthW-1:0] width_i,
  output logic [spwc_pkg::CmpW-1:0]   cmp_o
);

  logic [15:0] scaled;
  logic [31:0] prod;

  assign scaled = {1'b0, width_i, 4'b0000};
  assign prod   = scaled * spwc_pkg::RECIP5;
  assign cmp_o  = prod[spwc_pkg::RECIP5_SHIFT +: spwc_pkg::CmpW];

endmodule

// File: design/servo_pulse_width_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_pulse_width_controller_core
// Servo tester control: mode, pulse width and sweep direction per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one key event or periodic tick per item
//   (req_type_i, key_code_i, is_release_i) under in_valid_i / in_stall_o.
//   Output channel returns one result per item: pulse width, timer compare,
//   mode, sweep direction and a PWM-rewrite flag, under out_valid_o /
//   out_stall_i.
//   Path: an accepted item sits in the input register, then its result
//   in the result register. Throughput: one item per cycle unless the
//   receiver stalls; the state update and compare multiply lie between them.
//   Reset: mode manual, width 1500 us, sweep increasing, both stages empty.
//   Stall: a held result keeps the input register full; in_stall_o rises
//   only when both the input register and the result register are occupied
//   and the receiver stalls.
// ----------------------------------------------------------------------------
module servo_pulse_width_controller_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [spwc_pkg::KeyW-1:0]   key_code_i,
  input  logic                        is_release_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [spwc_pkg::WidthW-1:0] pulse_width_us_o,
  output logic [spwc_pkg::CmpW-1:0]   compare_value_o,
  output logic [1:0]                  mode_now_o,
  output logic                        sweep_up_o,
  output logic                        pwm_written_o
);

  logic                        in_valid_q;
  spwc_pkg::req_t              req_q;
  spwc_pkg::ctl_state_t        state_q, state_d;
  logic                        wrote_d;
  logic [spwc_pkg::CmpW-1:0]   cmp_d;
  logic                        out_ready;
  logic                        advance;
  logic                        in_take;

  logic                        out_valid_q;
  logic [spwc_pkg::WidthW-1:0] width_q;
  logic [spwc_pkg::CmpW-1:0]   cmp_q;
  logic [1:0]                  mode_q;
  logic                        dir_q;
  logic                        wrote_q;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  spwc_update u_update (
    .cur_i   (state_q),
    .req_i   (req_q),
    .nxt_o   (state_d),
    .wrote_o (wrote_d)
  );

  spwc_compare u_compare (
    .width_i (state_d.width),
    .cmp_o   (cmp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      state_q.mode   <= spwc_pkg::MODE_MANUAL;
      state_q.width  <= spwc_pkg::WIDTH_CENTER;
      state_q.dir_up <= 1'b1;
    end else begin
      if (in_take || advance)
        in_valid_q <= in_take;
      if (out_ready)
        out_valid_q <= in_valid_q;
      if (advance)
        state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take)
      req_q <= '{req_type: req_type_i, key_code: key_code_i, is_release: is_release_i};
    if (advance) begin
      width_q <= state_d.width;
      cmp_q   <= cmp_d;
      mode_q  <= state_d.mode;
      dir_q   <= state_d.dir_up;
      wrote_q <= wrote_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pulse_width_us_o = width_q;
  assign compare_value_o  = cmp_q;
  assign mode_now_o       = mode_q;
  assign sweep_up_o       = dir_q;
  assign pwm_written_o    = wrote_q;

  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pulse_width_us_o >= 11'd999) && (pulse_width_us_o <= 11'd2001))
    else $error("pulse width out of range");

  a_cmp_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({3'b000, compare_value_o} * 16'd5 <= {1'b0, pulse_width_us_o, 4'b0000})
                 && ({1'b0, pulse_width_us_o, 4'b0000} - {3'b000, compare_value_o} * 16'd5
                     < 16'd5))
    else $error("compare value does not match width");

  a_center_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pwm_written_o && (mode_now_o == spwc_pkg::MODE_CENTER)
     && (state_q.mode == spwc_pkg::MODE_CENTER))
    |-> (pulse_width_us_o >= 11'd999))
    else $error("center mode width invalid");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

endmodule

// File: verif/spwc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwc_result_checker
// Watches both channels of the servo pulse-width controller. It keeps its own
// copy of mode, width and sweep direction, predicts one result per accepted
// item and compares every accepted result field by field, in order.
// ----------------------------------------------------------------------------
module spwc_result_checker
  import spwc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              req_type_i,
  input  logic [KeyW-1:0]   key_code_i,
  input  logic              is_release_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [WidthW-1:0] pulse_width_us_i,
  input  logic [CmpW-1:0]   compare_value_i,
  input  logic [1:0]        mode_now_i,
  input  logic              sweep_up_i,
  input  logic              pwm_written_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [WidthW-1:0] width;
    logic [CmpW-1:0]   cmp;
    logic [1:0]        mode;
    logic              dir_up;
    logic              wrote;
  } servo_result_t;

  mode_e             mode_q;
  logic [WidthW-1:0] width_q;
  logic              dir_q;
  servo_result_t     expected_results[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic advance_controller(input logic req, input logic [KeyW-1:0] key,
                                    input logic rel, output servo_result_t res);
    logic        wrote;
    int unsigned w32;
    wrote = 1'b0;
    if (req == REQ_KEY) begin
      case (key)
        KEY_OK: begin
          if (rel) begin
            case (mode_q)
              MODE_CENTER: mode_q = MODE_MANUAL;
              MODE_MANUAL: mode_q = MODE_AUTO;
              default:     mode_q = MODE_CENTER;
            endcase
            if (mode_q == MODE_CENTER) begin
              width_q = WIDTH_CENTER;
              wrote   = 1'b1;
            end
          end
        end
        KEY_LEFT: begin
          if (width_q > WIDTH_MIN) width_q = width_q - STEP_FINE;
          wrote = 1'b1;
        end
        KEY_RIGHT: begin
          if (width_q < WIDTH_MAX) width_q = width_q + STEP_FINE;
          wrote = 1'b1;
        end
        KEY_DOWN: begin
          if (width_q >= SWEEP_LOW) width_q = width_q - STEP_COARSE;
          wrote = 1'b1;
        end
        KEY_UP: begin
          if (width_q <= SWEEP_HIGH) width_q = width_q + STEP_COARSE;
          wrote = 1'b1;
        end
        default: ;
      endcase
    end else if (mode_q == MODE_AUTO) begin
      width_q = dir_q ? width_q + STEP_FINE : width_q - STEP_FINE;
      if (width_q > SWEEP_HIGH || width_q < SWEEP_LOW) dir_q = ~dir_q;
      wrote = 1'b1;
    end
    // width * 3.2 as an exact fraction, truncated
    w32        = {21'd0, width_q};
    res.width  = width_q;
    res.cmp    = CmpW'((w32 * 16) / 5);
    res.mode   = mode_q;
    res.dir_up = dir_q;
    res.wrote  = wrote;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    servo_result_t want;
    servo_result_t next_res;
    if (!rst_ni) begin
      mode_q  = MODE_MANUAL;
      width_q = WIDTH_CENTER;
      dir_q   = 1'b1;
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, width", int'(pulse_width_us_i), -1);
        end else begin
          want = expected_results.pop_front();
          if (pulse_width_us_i !== want.width)
            report_mismatch("pulse_width_us", int'(pulse_width_us_i), int'(want.width));
          if (compare_value_i !== want.cmp)
            report_mismatch("compare_value", int'(compare_value_i), int'(want.cmp));
          if (mode_now_i !== want.mode)
            report_mismatch("mode_now", int'(mode_now_i), int'(want.mode));
          if (sweep_up_i !== want.dir_up)
            report_mismatch("sweep_up", int'(sweep_up_i), int'(want.dir_up));
          if (pwm_written_i !== want.wrote)
            report_mismatch("pwm_written", int'(pwm_written_i), int'(want.wrote));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_controller(req_type_i, key_code_i, is_release_i, next_res);
        expected_results.push_back(next_res);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// File: verif/tb_servo_pulse_width_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_pulse_width_controller_core
// Drives key events and ticks into the servo pulse-width controller with
// random gaps and output stalls. A short directed run covers each key, the
// mode cycle and ticks in every mode; the random run often enters auto mode,
// pushes the width to a limit and sweeps across the turn-around points.
// ----------------------------------------------------------------------------
module tb_servo_pulse_width_controller_core;
  import spwc_pkg::*;

  localparam logic [KeyW-1:0] KEY_OTHER = 3'd5;
  localparam int unsigned     ITEM_GOAL = 1450;
  localparam int unsigned     HOLD_OFF  = 60;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              req_type;
  logic [KeyW-1:0]   key_code;
  logic              is_release;
  logic              out_valid;
  logic              out_stall;
  logic [WidthW-1:0] pulse_width;
  logic [CmpW-1:0]   compare_value;
  logic [1:0]        mode_now;
  logic              sweep_up;
  logic              pwm_written;

  int    fail_count;
  int    pending;
  int    items_sent;
  int    stall_left;
  bit    calm;
  bit    hold_off_req;
  mode_e mode_guess;

  servo_pulse_width_controller_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .req_type_i       (req_type),
    .key_code_i       (key_code),
    .is_release_i     (is_release),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .pulse_width_us_o (pulse_width),
    .compare_value_o  (compare_value),
    .mode_now_o       (mode_now),
    .sweep_up_o       (sweep_up),
    .pwm_written_o    (pwm_written)
  );

  spwc_result_checker result_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .req_type_i       (req_type),
    .key_code_i       (key_code),
    .is_release_i     (is_release),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .pulse_width_us_i (pulse_width),
    .compare_value_i  (compare_value),
    .mode_now_i       (mode_now),
    .sweep_up_i       (sweep_up),
    .pwm_written_i    (pwm_written),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short, now and then long
  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic r, input logic [KeyW-1:0] k, input logic rl);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 60) ? 0 : pick_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= r;
    key_code   <= k;
    is_release <= rl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (r == REQ_KEY && k == KEY_OK && rl) begin
      case (mode_guess)
        MODE_CENTER: mode_guess = MODE_MANUAL;
        MODE_MANUAL: mode_guess = MODE_AUTO;
        default:     mode_guess = MODE_CENTER;
      endcase
    end
  endtask

  initial begin : receiver
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 25) begin
        stall_left = pick_len();
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin : stimulus
    logic up_dir;
    bit   did_hold;
    bit   did_pause;
    in_valid     = 1'b0;
    req_type     = REQ_KEY;
    key_code     = KEY_OK;
    is_release   = 1'b0;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    did_hold     = 1'b0;
    did_pause    = 1'b0;
    items_sent   = 0;
    mode_guess   = MODE_MANUAL;
    rst_n        = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    send_item(REQ_TICK, KEY_OK, 1'b1);     // tick in manual mode
    send_item(REQ_KEY, KEY_OK, 1'b0);      // OK press
    send_item(REQ_KEY, KEY_OTHER, 1'b1);   // unused key
    send_item(REQ_KEY, KEY_LEFT, 1'b0);
    send_item(REQ_KEY, KEY_RIGHT, 1'b1);
    send_item(REQ_KEY, KEY_DOWN, 1'b0);
    send_item(REQ_KEY, KEY_UP, 1'b1);
    send_item(REQ_KEY, KEY_OK, 1'b1);      // to auto
    send_item(REQ_TICK, KEY_OTHER, 1'b0);
    send_item(REQ_TICK, KEY_UP, 1'b1);
    send_item(REQ_KEY, KEY_OK, 1'b1);      // to center, recenters
    send_item(REQ_TICK, KEY_DOWN, 1'b0);   // tick in center mode
    send_item(REQ_KEY, KEY_UP, 1'b0);
    send_item(REQ_KEY, KEY_OK, 1'b1);      // back to manual

    while (items_sent < ITEM_GOAL) begin
      calm = ($urandom_range(0, 9) == 0);
      if (!did_hold && items_sent > 400) begin
        // receiver holds off while items keep coming
        did_hold     = 1'b1;
        calm         = 1'b1;
        hold_off_req = 1'b1;
        repeat (20) send_item(1'($urandom_range(0, 1)), KeyW'($urandom_range(0, 5)),
                              1'($urandom_range(0, 1)));
      end else if (!did_pause && items_sent > 900) begin
        did_pause = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // push to a limit, then sweep across the turn-around
            up_dir = 1'($urandom_range(0, 1));
            while (mode_guess != MODE_AUTO) send_item(REQ_KEY, KEY_OK, 1'b1);
            repeat ($urandom_range(15, 55))
              send_item(REQ_KEY, up_dir ? KEY_UP : KEY_DOWN, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 4))
              send_item(REQ_KEY, $urandom_range(0, 1) ? KEY_LEFT : KEY_RIGHT,
                        1'($urandom_range(0, 1)));
            repeat ($urandom_range(10, 45))
              send_item(REQ_TICK, KeyW'($urandom_range(0, 5)), 1'($urandom_range(0, 1)));
          end
          4, 5: begin
            repeat ($urandom_range(5, 30))
              send_item(REQ_TICK, KeyW'($urandom_range(0, 5)), 1'($urandom_range(0, 1)));
          end
          6, 7: begin
            repeat ($urandom_range(4, 15))
              send_item(($urandom_range(0, 3) == 0) ? REQ_TICK : REQ_KEY,
                        KeyW'($urandom_range(0, 5)), 1'($urandom_range(0, 1)));
          end
          default: send_item(REQ_KEY, KEY_OK, 1'($urandom_range(0, 1)));
        endcase
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("servo_pulse_width_controller_core test passed");
    end else begin
      $display("servo_pulse_width_controller_core test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("servo_pulse_width_controller_core test failed");
    $finish;
  end

endmodule
